// ===== hdl/fpa_pkg.sv =====
// ---------------------------------------------------------------------------
// fpa_pkg: shared types, constants and functions
// Operation codes, status codes, the divider cell record and saturation
// helpers for the fixed-point ALU.
// ---------------------------------------------------------------------------
package fpa_pkg;

  localparam int FracBits = 8;
  localparam int DataW    = 32;
  localparam int NumW     = DataW + FracBits;  // dividend width, one cell per bit
  localparam int RemW     = DataW + 1;

  typedef enum logic [3:0] {
    OpAdd   = 4'd0,
    OpSub   = 4'd1,
    OpMul   = 4'd2,
    OpDiv   = 4'd3,
    OpInc   = 4'd4,
    OpDec   = 4'd5,
    OpMin   = 4'd6,
    OpMax   = 4'd7,
    OpGt    = 4'd8,
    OpLt    = 4'd9,
    OpGe    = 4'd10,
    OpLe    = 4'd11,
    OpEq    = 4'd12,
    OpNe    = 4'd13,
    OpFrInt = 4'd14,
    OpToInt = 4'd15
  } op_e;

  localparam logic [1:0] StOk  = 2'd0;
  localparam logic [1:0] StOvf = 2'd1;
  localparam logic [1:0] StDz  = 2'd2;

  localparam logic [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic [DataW-1:0] val;
    logic [1:0]       st;
  } res_t;

  // result of non-divide ops plus divide control, carried along the chain
  typedef struct packed {
    logic             is_div;
    logic             neg;
    logic             dz;
    logic [DataW-1:0] res;
    logic             cmp;
    logic [1:0]       st;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [RemW-1:0]  rem;
    logic [NumW-1:0]  num;
    logic [NumW-1:0]  quo;
    logic [DataW-1:0] den;
  } div_t;

  // signed magnitude to saturated 32-bit two's complement
  function automatic res_t sat_mag(input logic neg, input logic [63:0] mag);
    res_t        r;
    logic [63:0] t;
    begin
      t    = 64'd0 - mag;
      r.st = StOk;
      if (neg) begin
        if (mag > {32'd0, MinVal}) begin
          r.val = MinVal;
          r.st  = StOvf;
        end else begin
          r.val = t[DataW-1:0];
        end
      end else begin
        if (mag > {32'd0, MaxVal}) begin
          r.val = MaxVal;
          r.st  = StOvf;
        end else begin
          r.val = mag[DataW-1:0];
        end
      end
      return r;
    end
  endfunction

  // 33-bit sum saturated to 32 bits
  function automatic res_t sat_sum(input logic [DataW:0] s);
    res_t r;
    begin
      r.st  = StOk;
      r.val = s[DataW-1:0];
      if (s[DataW] != s[DataW-1]) begin
        r.st  = StOvf;
        r.val = s[DataW] ? MinVal : MaxVal;
      end
      return r;
    end
  endfunction

endpackage

// ===== hdl/fpa_front.sv =====
// ---------------------------------------------------------------------------
// fpa_front: operand stage and non-divide datapath
// Registers the operands and the product, then evaluates every operation
// except the divide and loads the first divider cell.
// ---------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  op_e              op_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic             vld_o,
  output div_t             div_o
);

  logic             vld_a_q;
  op_e              op_a_q;
  logic [DataW-1:0] a_a_q, b_a_q;
  logic [63:0]      prod_a_q;
  logic             vld_b_q;
  div_t             div_b_q, div_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_a_q   <= op_i;
      a_a_q    <= a_i;
      b_a_q    <= b_i;
      // signed operands widen to the 64-bit target before the multiply
      prod_a_q <= $signed(a_i) * $signed(b_i);
      div_b_q  <= div_b_d;
    end
  end

  logic signed [DataW-1:0] sa, sb;
  logic [63:0]             pmag, prnd, wide;
  logic                    pneg;
  logic [DataW-1:0]        mag_a, mag_b;
  res_t                    r;

  always_comb begin
    sa      = $signed(a_a_q);
    sb      = $signed(b_a_q);
    pneg    = prod_a_q[63];
    pmag    = pneg ? (64'd0 - prod_a_q) : prod_a_q;
    prnd    = (pmag + (64'd1 << (FracBits - 1))) >> FracBits;
    wide    = 64'($signed(a_a_q)) << FracBits;
    mag_a   = a_a_q[DataW-1] ? (DataW'(0) - a_a_q) : a_a_q;
    mag_b   = b_a_q[DataW-1] ? (DataW'(0) - b_a_q) : b_a_q;
    r.val   = '0;
    r.st    = StOk;
    div_b_d = '0;
    case (op_a_q)
      OpAdd:   r = sat_sum({a_a_q[DataW-1], a_a_q} + {b_a_q[DataW-1], b_a_q});
      OpSub:   r = sat_sum({a_a_q[DataW-1], a_a_q} - {b_a_q[DataW-1], b_a_q});
      OpMul:   r = sat_mag(pneg, prnd);
      OpInc:   r = sat_sum({a_a_q[DataW-1], a_a_q} + (DataW+1)'(1));
      OpDec:   r = sat_sum({a_a_q[DataW-1], a_a_q} - (DataW+1)'(1));
      OpMin:   r.val = (sa < sb) ? a_a_q : b_a_q;
      OpMax:   r.val = (sa < sb) ? b_a_q : a_a_q;
      OpGt:    div_b_d.side.cmp = sa > sb;
      OpLt:    div_b_d.side.cmp = sa < sb;
      OpGe:    div_b_d.side.cmp = sa >= sb;
      OpLe:    div_b_d.side.cmp = sa <= sb;
      OpEq:    div_b_d.side.cmp = sa == sb;
      OpNe:    div_b_d.side.cmp = sa != sb;
      OpFrInt: begin
        if (wide[63:DataW-1] == {(65-DataW){wide[63]}}) begin
          r.val = wide[DataW-1:0];
        end else begin
          r.val = wide[63] ? MinVal : MaxVal;
          r.st  = StOvf;
        end
      end
      OpToInt: r.val = DataW'(sa >>> FracBits);
      OpDiv: begin
        div_b_d.side.is_div = 1'b1;
        div_b_d.side.neg    = a_a_q[DataW-1] ^ b_a_q[DataW-1];
        div_b_d.side.dz     = (b_a_q == '0);
        if (b_a_q == '0) begin
          r.st  = StDz;
          r.val = (a_a_q == '0) ? '0 : (a_a_q[DataW-1] ? MinVal : MaxVal);
        end
      end
      default: r.val = '0;
    endcase
    div_b_d.side.res = r.val;
    div_b_d.side.st  = r.st;
    div_b_d.num      = {mag_a, {FracBits{1'b0}}};
    div_b_d.den      = mag_b;
  end

  assign vld_o = vld_b_q;
  assign div_o = div_b_q;

endmodule

// ===== hdl/fpa_cell.sv =====
// ---------------------------------------------------------------------------
// fpa_cell: one restoring divider cell
// Brings in the next dividend bit, trial-subtracts the divisor and shifts
// one quotient bit in; everything else rides along to the next cell.
// ---------------------------------------------------------------------------
module fpa_cell import fpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  div_t div_i,
  output logic vld_o,
  output div_t div_o
);

  logic            vld_q;
  div_t            div_q, div_d;
  logic [RemW-1:0] trial;
  logic            ge;

  always_comb begin
    trial     = {div_i.rem[RemW-2:0], div_i.num[NumW-1]};
    ge        = trial >= {1'b0, div_i.den};
    div_d     = div_i;
    div_d.rem = ge ? (trial - {1'b0, div_i.den}) : trial;
    div_d.num = {div_i.num[NumW-2:0], 1'b0};
    div_d.quo = {div_i.quo[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

endmodule

// ===== hdl/fpa_back.sv =====
// ---------------------------------------------------------------------------
// fpa_back: quotient rounding and output register
// Rounds the quotient half away from zero, saturates it and selects the
// final result.
// ---------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  div_t             div_i,
  output logic             vld_o,
  output logic [DataW-1:0] res_o,
  output logic             cmp_o,
  output logic [1:0]       st_o
);

  logic             vld_q;
  logic [DataW-1:0] res_q;
  logic             cmp_q;
  logic [1:0]       st_q;
  logic             up;
  logic [63:0]      qr;
  res_t             r;

  always_comb begin
    // remainder at least half the divisor rounds the magnitude up
    up = {div_i.rem, 1'b0} >= {2'b00, div_i.den};
    qr = 64'(div_i.quo) + 64'(up);
    r  = sat_mag(div_i.side.neg, qr);
    if (!div_i.side.is_div || div_i.side.dz) begin
      r.val = div_i.side.res;
      r.st  = div_i.side.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= r.val;
      st_q  <= r.st;
      cmp_q <= div_i.side.cmp;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;
  assign cmp_o = cmp_q;
  assign st_o  = st_q;

endmodule

// ===== hdl/fixed_point_q24_8_alu.sv =====
// ---------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 fixed-point ALU
// Streaming ALU with saturating arithmetic, exact rounded multiply/divide.
// ---------------------------------------------------------------------------
// Takes one transfer per cycle while the pipeline advances and returns each result in
// input order after two operand/product stages, a chain of 40 restoring divider
// cells (one quotient bit each, 32 + 8 fraction bits) and the output
// register. Every operation passes the same chain so order is kept. The
// whole pipeline advances while the output register is empty or being
// taken, so s_axis_tready follows m_axis_tready combinationally.
module fixed_point_q24_8_alu import fpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [3:0]  s_axis_tuser,   // [3:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_value
  output logic [2:0]  m_axis_tuser    // [0] compare_true, [2:1] status
);

  logic adv;
  logic vld_c [NumW+1];
  div_t div_c [NumW+1];

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  fpa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s_axis_tvalid),
    .op_i   (op_e'(s_axis_tuser)),
    .a_i    (s_axis_tdata[31:0]),
    .b_i    (s_axis_tdata[63:32]),
    .vld_o  (vld_c[0]),
    .div_o  (div_c[0])
  );

  for (genvar i = 0; i < NumW; i++) begin : g_cell
    fpa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (vld_c[i]),
      .div_i  (div_c[i]),
      .vld_o  (vld_c[i+1]),
      .div_o  (div_c[i+1])
    );
  end

  fpa_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vld_c[NumW]),
    .div_i  (div_c[NumW]),
    .vld_o  (m_axis_tvalid),
    .res_o  (m_axis_tdata),
    .cmp_o  (m_axis_tuser[0]),
    .st_o   (m_axis_tuser[2:1])
  );

endmodule

// ===== hdl/fpa_checker.sv =====
// ---------------------------------------------------------------------------
// fpa_checker: port-level checks
// Watches the result stream of the ALU for illegal combinations.
// ---------------------------------------------------------------------------
module fpa_checker import fpa_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[2:1] != 2'b11)
    else $error("undefined status code");

  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == StOk && m_axis_tdata == '0)
    else $error("comparison transfer carries data or status");

  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:1] == StDz |->
      m_axis_tdata == '0 || m_axis_tdata == MaxVal || m_axis_tdata == MinVal)
    else $error("divide by zero result not saturated");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/tb_fixed_point_q24_8_alu.sv =====
// ---------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu: stream testbench for the Q24.8 ALU
// Drives operation/operand transfers with random gaps, predicts each result
// with an exact 64-bit model and checks results in order as they arrive.
// ---------------------------------------------------------------------------
module tb_fixed_point_q24_8_alu;
  import fpa_pkg::*;

  localparam int Latency  = 43;
  localparam int StallMax = 2000;

  typedef struct packed {
    logic [31:0] val;
    logic        cmp;
    logic [1:0]  st;
  } alu_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  alu_res_t expected_q[$];
  int       n_fail = 0;
  int       idle_cycles = 0;
  bit       quiet = 1'b0;     // no idling in the last part
  bit       hold_rx = 1'b0;   // long receiver hold-off

  always #2 clk_i = ~clk_i;

  fixed_point_q24_8_alu dut (.*);

  function automatic alu_res_t sat_val(input logic signed [63:0] v);
    alu_res_t r;
    r = '0;
    if (v > 64'sd2147483647) begin
      r.val = MaxVal; r.st = StOvf;
    end else if (v < -64'sd2147483648) begin
      r.val = MinVal; r.st = StOvf;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic alu_res_t alu_predict(input op_e op, input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_res_t           r;
    logic signed [63:0] a64, b64, p;
    logic        [63:0] m, num, den;
    a64 = a;
    b64 = b;
    r = '0;
    case (op)
      OpAdd:   r = sat_val(a64 + b64);
      OpSub:   r = sat_val(a64 - b64);
      OpInc:   r = sat_val(a64 + 1);
      OpDec:   r = sat_val(a64 - 1);
      OpFrInt: r = sat_val(a64 * 256);
      OpMul: begin
        p = a64 * b64;
        m = (p < 0) ? -p : p;
        m = (m + 64'd128) >> FracBits;
        r = sat_val((p < 0) ? -$signed(m) : $signed(m));
      end
      OpDiv: begin
        if (b == 0) begin
          r.st  = StDz;
          r.val = (a > 0) ? MaxVal : ((a < 0) ? MinVal : '0);
        end else begin
          num = ((a64 < 0) ? -a64 : a64) << FracBits;
          den = (b64 < 0) ? -b64 : b64;
          m = (2 * num + den) / (2 * den);
          r = sat_val(((a < 0) != (b < 0)) ? -$signed(m) : $signed(m));
        end
      end
      OpMin:   r.val = (a < b) ? a : b;
      OpMax:   r.val = (a < b) ? b : a;
      OpGt:    r.cmp = a > b;
      OpLt:    r.cmp = a < b;
      OpGe:    r.cmp = a >= b;
      OpLe:    r.cmp = a <= b;
      OpEq:    r.cmp = a == b;
      OpNe:    r.cmp = a != b;
      default: r.val = a >>> FracBits;
    endcase
    return r;
  endfunction

  // one transfer; prediction is queued at acceptance
  task automatic send_op(input op_e op, input logic [31:0] a, input logic [31:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(alu_predict(op, a, b));
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return MaxVal - $urandom_range(0, 3);
      1: return MinVal + $urandom_range(0, 3);
      2: return $urandom_range(0, 4096) - 2048;
      3: return {{16{1'b0}}, 16'($urandom)} ^ {32{1'($urandom)}};
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls, checked at each accepted transfer
  always @(negedge clk_i) begin
    if (!rst_ni || hold_rx) m_axis_tready <= 1'b0;
    else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
    end else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    alu_res_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        n_fail++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata !== exp_r.val) begin
          $error("result_value exp %h got %h", exp_r.val, m_axis_tdata); n_fail++;
        end
        if (m_axis_tuser[0] !== exp_r.cmp) begin
          $error("compare_true exp %b got %b", exp_r.cmp, m_axis_tuser[0]); n_fail++;
        end
        if (m_axis_tuser[2:1] !== exp_r.st) begin
          $error("status exp %0d got %0d", exp_r.st, m_axis_tuser[2:1]); n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallMax) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] edges[6];
    edges = '{32'h0, 32'h100, MaxVal, MinVal, 32'hFFFF_FF00, 32'hFFFF_FFFF};
    for (int op = 0; op < 16; op++) send_op(op_e'(op), edges[op % 6], edges[(op + 2) % 6]);
    send_op(OpDiv, 32'h500, 32'h0);
    send_op(OpDiv, MinVal, 32'h0);
    send_op(OpDiv, 32'h0, 32'h0);
    send_op(OpDiv, MinVal, 32'hFFFF_FFFF);
    send_op(OpMul, 32'h180, 32'h1);     // tie rounds away from zero
    send_op(OpMul, 32'hFFFF_FE80, 32'h1);
    send_op(OpInc, MaxVal, 32'h0);
    send_op(OpDec, MinVal, 32'h0);
    send_op(OpFrInt, 32'h0080_0000, 32'h0);
    send_op(OpToInt, 32'hFFFF_FF01, 32'h0);
    send_op(OpMin, 32'h42, 32'h42);
    idle_input();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_op(op_e'($urandom_range(0, 15)), rand_operand(), rand_operand());
    idle_input();
  endtask

  // receiver holds off while input keeps offering, filling the pipeline
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (120) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      test_random(80);
    join
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500);
    test_backpressure();
    quiet = 1'b1;
    test_random(200);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
    if (n_fail == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
